// ===== sv/axis_angle_vector_rotate_top_macros.svh =====
// Assertion macros used by the checker file aavr_checker.sv.
`ifndef AXIS_ANGLE_VECTOR_ROTATE_TOP_MACROS_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_TOP_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define AAVR_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger that must be followed by a condition on the next edge.
`define AAVR_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== sv/aavr_pkg.sv =====
// ----------------------------------------------------------------------------
// aavr_pkg
// Widths, angle constants, arctangent table and pipeline word types of the
// axis-angle vector rotator.
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int VEC_W  = 32;
  localparam int AXIS_W = 18;
  localparam int ANG_W  = 25;
  localparam int RED_W  = 36;
  localparam int CORD_W = 33;
  localparam int ATAN_N = 30;
  localparam int CS_W   = 18;
  localparam int T_W    = 19;
  localparam int KK_W   = 36;
  localparam int SK_W   = 36;
  localparam int M_W    = 54;
  localparam int ME_W   = 30;
  localparam int ACC_W  = 64;

  localparam logic signed [RED_W-1:0]  TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [RED_W-1:0]  PI_Q30      = 36'sd3373259426;
  localparam logic signed [RED_W-1:0]  HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CORD_W-1:0] GAIN_Q30    = 33'sd652032874;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic signed [CORD_W-1:0] atan_q30(input int idx);
    logic signed [CORD_W-1:0] val;
    case (idx)
      0:       val = 33'sd843314857;
      1:       val = 33'sd497837829;
      2:       val = 33'sd263043837;
      3:       val = 33'sd133525159;
      4:       val = 33'sd67021687;
      5:       val = 33'sd33543516;
      6:       val = 33'sd16775851;
      7:       val = 33'sd8388437;
      8:       val = 33'sd4194283;
      9:       val = 33'sd2097149;
      default: val = CORD_W'(64'sd1 <<< (30 - idx));
    endcase
    return val;
  endfunction

  typedef struct packed {
    logic signed [VEC_W-1:0]  vx;
    logic signed [VEC_W-1:0]  vy;
    logic signed [VEC_W-1:0]  vz;
    logic signed [AXIS_W-1:0] kx;
    logic signed [AXIS_W-1:0] ky;
    logic signed [AXIS_W-1:0] kz;
  } aavr_side_t;

  typedef struct packed {
    logic                     valid;
    logic                     neg;
    aavr_side_t               side;
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
  } aavr_cord_t;

  typedef struct packed {
    logic                    valid;
    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;
    logic signed [VEC_W-1:0] rot_z;
  } aavr_res_t;

endpackage

// ===== sv/aavr_if.sv =====
// ----------------------------------------------------------------------------
// aavr_in_if / aavr_out_if
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface aavr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [17:0] axis_x;
  logic signed [17:0] axis_y;
  logic signed [17:0] axis_z;
  logic signed [24:0] angle;

  modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                output ready);
endinterface

interface aavr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;

  modport source (output valid, rot_x, rot_y, rot_z, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

// ===== sv/aavr_reduce.sv =====
// ----------------------------------------------------------------------------
// aavr_reduce
// Three-stage angle reduction into [-pi/2, pi/2] with a sign flag, feeding
// the first CORDIC cell.
// ----------------------------------------------------------------------------
module aavr_reduce import aavr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [ANG_W-1:0] in_angle,
  input  aavr_side_t              in_side,
  output aavr_cord_t              cord_o
);

  logic                    v1_r, v2_r;
  aavr_side_t              side1_r, side2_r;
  logic signed [RED_W-1:0] red1_r, red1_nxt, red2_r, red2_nxt;
  aavr_cord_t              cord_r, cord_nxt;

  // floor-modulo by two pi: pick the one candidate in [0, 2pi)
  always_comb begin
    logic signed [RED_W-1:0] r0;
    logic signed [RED_W-1:0] cand;
    r0       = RED_W'(in_angle) <<< 10;
    red1_nxt = r0;
    for (int q = 0; q < 6; q++) begin
      cand = r0 - RED_W'(q - 3) * TWO_PI_Q30;
      if (cand >= 0 && cand < TWO_PI_Q30) red1_nxt = cand;
    end
  end

  // wrap above pi
  assign red2_nxt = (red1_r > PI_Q30) ? red1_r - TWO_PI_Q30 : red1_r;

  // fold into the right half plane
  always_comb begin
    logic signed [RED_W-1:0] zr;
    zr           = red2_r;
    cord_nxt.neg = 1'b0;
    if (red2_r > HALF_PI_Q30) begin
      zr           = red2_r - PI_Q30;
      cord_nxt.neg = 1'b1;
    end else if (red2_r < -HALF_PI_Q30) begin
      zr           = red2_r + PI_Q30;
      cord_nxt.neg = 1'b1;
    end
    cord_nxt.valid = v2_r;
    cord_nxt.side  = side2_r;
    cord_nxt.x     = GAIN_Q30;
    cord_nxt.y     = '0;
    cord_nxt.z     = zr[CORD_W-1:0];
  end

  // advance the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      cord_r.valid <= 1'b0;
    end else if (en) begin
      v1_r    <= in_valid;
      side1_r <= in_side;
      red1_r  <= red1_nxt;
      v2_r    <= v1_r;
      side2_r <= side1_r;
      red2_r  <= red2_nxt;
      cord_r  <= cord_nxt;
    end
  end

  assign cord_o = cord_r;

endmodule

// ===== sv/aavr_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// aavr_cordic_cell
// One rotation-mode CORDIC step with its shift and arctangent fixed by the
// cell's place in the chain.
// ----------------------------------------------------------------------------
module aavr_cordic_cell import aavr_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  aavr_cord_t cord_i,
  output aavr_cord_t cord_o
);

  localparam logic signed [CORD_W-1:0] ATAN = atan_q30(STAGE);

  aavr_cord_t cord_r, cord_nxt;

  // rotate toward zero residual angle
  always_comb begin
    logic signed [CORD_W-1:0] dx, dy;
    dx       = cord_i.y >>> STAGE;
    dy       = cord_i.x >>> STAGE;
    cord_nxt = cord_i;
    if (!cord_i.z[CORD_W-1]) begin
      cord_nxt.x = cord_i.x - dx;
      cord_nxt.y = cord_i.y + dy;
      cord_nxt.z = cord_i.z - ATAN;
    end else begin
      cord_nxt.x = cord_i.x + dx;
      cord_nxt.y = cord_i.y - dy;
      cord_nxt.z = cord_i.z + ATAN;
    end
  end

  // hand the word to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cord_r.valid <= 1'b0;
    end else if (en) begin
      cord_r <= cord_nxt;
    end
  end

  assign cord_o = cord_r;

endmodule

// ===== sv/aavr_rodrigues.sv =====
// ----------------------------------------------------------------------------
// aavr_rodrigues
// Five-stage matrix build and matrix-vector product with rounding and
// saturation of each rotated component.
// ----------------------------------------------------------------------------
module aavr_rodrigues import aavr_pkg::*; #(
  parameter int COMP_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  aavr_cord_t cord_i,
  output aavr_res_t  res_o
);

  localparam logic signed [ACC_W-1:0] SAT_HI = (64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] SAT_LO = -(64'sd1 <<< (COMP_WIDTH - 1));

  logic                    va_r, vb_r, vc_r, vd_r;
  logic signed [VEC_W-1:0] vec_a_r [3], vec_b_r [3], vec_c_r [3];
  logic signed [AXIS_W-1:0] k_a_r [3];
  logic signed [CS_W-1:0]  c_a_r, s_a_r, c_b_r;
  logic signed [T_W-1:0]   t_a_r;
  logic signed [KK_W-1:0]  kk_a_r [3][3];
  logic signed [M_W-1:0]   tkk_b_r [3][3];
  logic signed [SK_W-1:0]  sk_b_r [3];
  logic signed [ME_W-1:0]  me_c_r [3][3];
  logic signed [ACC_W-1:0] p_d_r [3][3];
  aavr_res_t               res_r, res_nxt;

  // stage A: round cosine and sine, form axis products
  logic signed [CS_W-1:0]   c_nxt, s_nxt;
  logic signed [AXIS_W-1:0] k_in [3];
  always_comb begin
    logic signed [CORD_W:0] cx, sy, cr, sr;
    cx    = cord_i.neg ? -(CORD_W+1)'(cord_i.x) : (CORD_W+1)'(cord_i.x);
    sy    = cord_i.neg ? -(CORD_W+1)'(cord_i.y) : (CORD_W+1)'(cord_i.y);
    cr    = (cx + (CORD_W+1)'(1 << 13)) >>> 14;
    sr    = (sy + (CORD_W+1)'(1 << 13)) >>> 14;
    c_nxt = cr[CS_W-1:0];
    s_nxt = sr[CS_W-1:0];
    k_in[0] = cord_i.side.kx;
    k_in[1] = cord_i.side.ky;
    k_in[2] = cord_i.side.kz;
  end

  // stage E: sum, round, saturate
  always_comb begin
    logic signed [ACC_W-1:0] acc, rr, st;
    logic signed [VEC_W-1:0] rot [3];
    for (int a = 0; a < 3; a++) begin
      acc = p_d_r[a][0] + p_d_r[a][1] + p_d_r[a][2];
      rr  = (acc + (ACC_W)'(1 << 23)) >>> 24;
      if (rr > SAT_HI)      st = SAT_HI;
      else if (rr < SAT_LO) st = SAT_LO;
      else                  st = rr;
      rot[a] = st[VEC_W-1:0];
    end
    res_nxt.valid = vd_r;
    res_nxt.rot_x = rot[0];
    res_nxt.rot_y = rot[1];
    res_nxt.rot_z = rot[2];
  end

  // hold valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      res_r.valid <= 1'b0;
    end else if (en) begin
      va_r  <= cord_i.valid;
      vb_r  <= va_r;
      vc_r  <= vb_r;
      vd_r  <= vc_r;
      res_r <= res_nxt;
    end
  end

  // advance the arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      vec_a_r[0] <= cord_i.side.vx;
      vec_a_r[1] <= cord_i.side.vy;
      vec_a_r[2] <= cord_i.side.vz;
      c_a_r <= c_nxt;
      s_a_r <= s_nxt;
      t_a_r <= T_W'(65536) - T_W'(c_nxt);
      c_b_r <= c_a_r;
      for (int a = 0; a < 3; a++) begin
        k_a_r[a]   <= k_in[a];
        vec_b_r[a] <= vec_a_r[a];
        vec_c_r[a] <= vec_b_r[a];
        sk_b_r[a]  <= SK_W'(s_a_r) * SK_W'(k_a_r[a]);
        for (int b = 0; b < 3; b++) begin
          kk_a_r[a][b]  <= KK_W'(k_in[a]) * KK_W'(k_in[b]);
          tkk_b_r[a][b] <= M_W'(t_a_r) * M_W'(kk_a_r[a][b]);
          p_d_r[a][b]   <= ACC_W'(me_c_r[a][b]) * ACC_W'(vec_c_r[b]);
        end
      end
    end
  end

  function automatic logic signed [M_W-1:0] m_val(input int a, input int b);
    logic signed [M_W-1:0] m;
    logic signed [M_W-1:0] sk0, sk1, sk2;
    sk0 = M_W'(sk_b_r[0]) <<< 16;
    sk1 = M_W'(sk_b_r[1]) <<< 16;
    sk2 = M_W'(sk_b_r[2]) <<< 16;
    m = tkk_b_r[a][b];
    if (a == b) m = m + (M_W'(c_b_r) <<< 32);
    if (a == 0 && b == 1) m = m - sk2;
    if (a == 1 && b == 0) m = m + sk2;
    if (a == 0 && b == 2) m = m + sk1;
    if (a == 2 && b == 0) m = m - sk1;
    if (a == 1 && b == 2) m = m - sk0;
    if (a == 2 && b == 1) m = m + sk0;
    return m + M_W'(1 << 23);
  endfunction

  // stage C: matrix entries in Q48, rounded to Q24
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          me_c_r[a][b] <= ME_W'(m_val(a, b) >>> 24);
        end
      end
    end
  end

  assign res_o = res_r;

endmodule

// ===== sv/axis_angle_vector_rotate_top.sv =====
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_top
// Rodrigues rotation of a Q16.16 vector about a Q2.16 axis by a Q5.20 angle.
// ----------------------------------------------------------------------------
// Fully pipelined: one word is accepted every cycle while the output is not
// stalled. The pipeline has 3 angle-reduction stages, one CORDIC cell per
// stage (CORDIC_STAGES cells, capped at ATAN_N), and 5 matrix and product
// stages, the last being the output register. While a result waits at the
// output the whole pipeline holds, and in_ch.ready follows that hold.
// COMP_WIDTH sets the saturation range of each component; the output keeps its low 32 bits.
module axis_angle_vector_rotate_top import aavr_pkg::*; #(
  parameter int COMP_WIDTH    = 32,
  parameter int CORDIC_STAGES = 18
) (
  input  logic       clk,
  input  logic       rst_n,
  aavr_in_if.sink    in_ch,
  aavr_out_if.source out_ch
);

  localparam int NCELL = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;

  logic       en;
  aavr_side_t side_in;
  aavr_cord_t cord [NCELL+1];
  aavr_res_t  res;

  // advance whenever the output word is free or being taken
  assign en          = !res.valid || out_ch.ready;
  assign in_ch.ready = en;

  assign side_in.vx = in_ch.vec_x;
  assign side_in.vy = in_ch.vec_y;
  assign side_in.vz = in_ch.vec_z;
  assign side_in.kx = in_ch.axis_x;
  assign side_in.ky = in_ch.axis_y;
  assign side_in.kz = in_ch.axis_z;

  aavr_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_angle (in_ch.angle),
    .in_side  (side_in),
    .cord_o   (cord[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    aavr_cordic_cell #(.STAGE(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .cord_i (cord[g]),
      .cord_o (cord[g+1])
    );
  end

  aavr_rodrigues #(.COMP_WIDTH(COMP_WIDTH)) u_rod (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .cord_i (cord[NCELL]),
    .res_o  (res)
  );

  assign out_ch.valid = res.valid;
  assign out_ch.rot_x = res.rot_x;
  assign out_ch.rot_y = res.rot_y;
  assign out_ch.rot_z = res.rot_z;

endmodule

// ===== sv/aavr_checker.sv =====
// ----------------------------------------------------------------------------
// aavr_checker
// Port-level checks of the rotator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "axis_angle_vector_rotate_top_macros.svh"

module aavr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rot_x,
  input logic [31:0] rot_y,
  input logic [31:0] rot_z
);

  logic [7:0] pend_r;

  // count words in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end
  end

  `AAVR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `AAVR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(rot_x) && $stable(rot_y) && $stable(rot_z), "result changed while stalled")
  `AAVR_ASSERT_ALWAYS(a_no_phantom, clk, rst_n, !out_valid || pend_r != 8'd0, "result without an accepted word")
  `AAVR_ASSERT_ALWAYS(a_ready_free, clk, rst_n, out_valid || in_ready, "input stalled with empty output")

endmodule

bind axis_angle_vector_rotate_top aavr_checker u_aavr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .rot_x     (out_ch.rot_x),
  .rot_y     (out_ch.rot_y),
  .rot_z     (out_ch.rot_z)
);

// ===== verif/aavr_tb_if.sv =====
// ----------------------------------------------------------------------------
// aavr_tb_if
// Testbench copies of the rotator channels are not needed: the block's own
// interfaces are used. This file holds the input and result word types shared
// by the testbench tasks and the scoreboard.
// ----------------------------------------------------------------------------
package aavr_tb_pkg;

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [17:0] kx;
    logic signed [17:0] ky;
    logic signed [17:0] kz;
    logic signed [24:0] ang;
  } rot_req_t;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
  } rot_vec_t;

endpackage

// ===== verif/axis_angle_vector_rotate_top_tb.sv =====
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_top_tb
// Drives directed and random rotation words through the rotator with random
// gaps and output stalls, predicts each rotated vector in fixed point and
// compares every result word field by field in order.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate_top_tb;
  import aavr_pkg::*;
  import aavr_tb_pkg::*;

  localparam int COMP_W   = 32;
  localparam int STAGES   = 18;
  localparam int LATENCY  = STAGES + 8;
  localparam int N_RAND   = 1600;
  localparam int MAX_CYC  = 400000;

  // constants of the sine/cosine path, Q30
  localparam longint TWO_PI  = 64'sd6746518852;
  localparam longint PI_VAL  = 64'sd3373259426;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint GAIN    = 64'sd652032874;

  logic clk;
  logic rst_n;
  int   n_err;
  int   cyc;
  bit   hold_long;

  aavr_in_if  in_ch ();
  aavr_out_if out_ch ();

  axis_angle_vector_rotate_top #(
    .COMP_WIDTH(COMP_W),
    .CORDIC_STAGES(STAGES)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic report(input string what);
    n_err++;
    $display("mismatch at cycle %0d: %s", cyc, what);
  endtask

  function automatic longint rnd_sh(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint arctan_step(input int i);
    case (i)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return 64'sd1 <<< (30 - i);
    endcase
  endfunction

  // Rodrigues rotation in fixed point
  function automatic rot_vec_t rotate_vec(input rot_req_t q);
    longint r, x, y, z, dx, dy, c, s, t, acc;
    longint v[3], k[3], m[3][3];
    bit neg;
    rot_vec_t res;
    r = longint'(q.ang) * 1024;
    r = r % TWO_PI;
    if (r < 0) r += TWO_PI;
    if (r > PI_VAL) r -= TWO_PI;
    neg = 1'b0;
    if (r > HALF_PI) begin
      r -= PI_VAL;
      neg = 1'b1;
    end else if (r < -HALF_PI) begin
      r += PI_VAL;
      neg = 1'b1;
    end
    x = GAIN;
    y = 0;
    z = r;
    for (int i = 0; i < STAGES && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= arctan_step(i);
      end else begin
        x += dx;
        y -= dy;
        z += arctan_step(i);
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = rnd_sh(x, 14);
    s = rnd_sh(y, 14);
    t = 65536 - c;
    v[0] = longint'(q.vx); v[1] = longint'(q.vy); v[2] = longint'(q.vz);
    k[0] = longint'(q.kx); k[1] = longint'(q.ky); k[2] = longint'(q.kz);
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        m[a][b] = t * k[a] * k[b];
    for (int a = 0; a < 3; a++)
      m[a][a] += c * 64'sd4294967296;
    m[0][1] -= k[2] * s * 65536;
    m[1][0] += k[2] * s * 65536;
    m[0][2] += k[1] * s * 65536;
    m[2][0] -= k[1] * s * 65536;
    m[1][2] -= k[0] * s * 65536;
    m[2][1] += k[0] * s * 65536;
    for (int a = 0; a < 3; a++) begin
      acc = 0;
      for (int b = 0; b < 3; b++)
        acc += rnd_sh(m[a][b], 24) * v[b];
      acc = rnd_sh(acc, 24);
      if (acc > (64'sd1 <<< (COMP_W - 1)) - 1) acc = (64'sd1 <<< (COMP_W - 1)) - 1;
      if (acc < -(64'sd1 <<< (COMP_W - 1))) acc = -(64'sd1 <<< (COMP_W - 1));
      if (a == 0) res.rx = acc[31:0];
      else if (a == 1) res.ry = acc[31:0];
      else res.rz = acc[31:0];
    end
    return res;
  endfunction

  class rot_scoreboard;
    rot_vec_t pending[$];

    function void note_word(input rot_req_t q);
      pending.push_back(rotate_vec(q));
    endfunction

    task check_word(input rot_vec_t got);
      rot_vec_t want;
      if (pending.size() == 0) begin
        report("result word with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (got.rx !== want.rx)
        report($sformatf("rot_x got %h want %h", got.rx, want.rx));
      if (got.ry !== want.ry)
        report($sformatf("rot_y got %h want %h", got.ry, want.ry));
      if (got.rz !== want.rz)
        report($sformatf("rot_z got %h want %h", got.rz, want.rz));
    endtask
  endclass

  rot_scoreboard sb = new();

  // drop valid and hold off for a randomly drawn gap
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (n != 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_word(input rot_req_t q, input bit gaps);
    if (gaps) idle_gap();
    in_ch.valid  <= 1'b1;
    in_ch.vec_x  <= q.vx;
    in_ch.vec_y  <= q.vy;
    in_ch.vec_z  <= q.vz;
    in_ch.axis_x <= q.kx;
    in_ch.axis_y <= q.ky;
    in_ch.axis_z <= q.kz;
    in_ch.angle  <= q.ang;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(q);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [17:0] unit_comp();
    case ($urandom_range(0, 5))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'sd0;
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic rot_req_t rand_word();
    rot_req_t q;
    q.vx = $urandom();
    q.vy = $urandom();
    q.vz = $urandom();
    if ($urandom_range(0, 2) != 0) begin
      q.vx = q.vx >>> $urandom_range(0, 16);
      q.vy = q.vy >>> $urandom_range(0, 16);
      q.vz = q.vz >>> $urandom_range(0, 16);
    end
    if ($urandom_range(0, 4) == 0) begin
      q.kx = 18'($urandom());
      q.ky = 18'($urandom());
      q.kz = 18'($urandom());
    end else begin
      q.kx = unit_comp();
      q.ky = unit_comp();
      q.kz = unit_comp();
    end
    q.ang = 25'($urandom());
    if ($urandom_range(0, 1) != 0) q.ang = q.ang >>> $urandom_range(0, 4);
    return q;
  endfunction

  function automatic rot_req_t mk(input longint vx, vy, vz, kx, ky, kz, ang);
    rot_req_t q;
    q.vx = 32'(vx); q.vy = 32'(vy); q.vz = 32'(vz);
    q.kx = 18'(kx); q.ky = 18'(ky); q.kz = 18'(kz);
    q.ang = 25'(ang);
    return q;
  endfunction

  // receiver: random stalls, plus one long hold while the sender keeps going
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_long = 1'b0;
      end else begin
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 1) == 0) n = 0;
        if (n != 0) begin
          out_ch.ready <= 1'b0;
          repeat (n - 1) @(negedge clk);
          @(negedge clk);
        end
      end
      out_ch.ready <= 1'b1;
    end
  end

  // check every accepted result word
  always @(posedge clk) begin
    rot_vec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.rx = out_ch.rot_x;
      got.ry = out_ch.rot_y;
      got.rz = out_ch.rot_z;
      sb.check_word(got);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rot_req_t dq[$];
    n_err = 0;
    cyc = 0;
    hold_long = 1'b0;
    rst_n = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.vec_x  = '0;
    in_ch.vec_y  = '0;
    in_ch.vec_z  = '0;
    in_ch.axis_x = '0;
    in_ch.axis_y = '0;
    in_ch.axis_z = '0;
    in_ch.angle  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, zero and non-unit axes, large angles, overflow
    dq.push_back(mk(65536, 0, 0, 0, 0, 65536, 1647099));
    dq.push_back(mk(65536, 131072, -65536, 65536, 0, 0, -1647099));
    dq.push_back(mk(12345, -9876, 5555, 0, 0, 0, 1000000));
    dq.push_back(mk(65536, 65536, 65536, 0, 0, 0, 3294199));
    dq.push_back(mk(-2147483648, -2147483648, -2147483648, 131071, 131071, 131071, 0));
    dq.push_back(mk(2147483647, 2147483647, 2147483647, -131072, -131072, -131072, 0));
    dq.push_back(mk(2147483647, -2147483648, 2147483647, 131071, -131072, 0, 16777215));
    dq.push_back(mk(2147483647, 2147483647, -2147483648, 0, 65536, 0, -16777216));
    dq.push_back(mk(1000, 2000, 3000, 37837, 37837, 37837, 6588397));
    dq.push_back(mk(1000, 2000, 3000, 0, 65536, 0, -3294199));
    dq.push_back(mk(-1, -1, -1, -1, -1, -1, -1));
    dq.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    dq.push_back(mk(2147483647, 2147483647, 2147483647, 131071, 131071, 131071, 1647099));
    dq.push_back(mk(7 <<< 16, -3 <<< 16, 5 <<< 16, 0, -65536, 0, 6588397 + 1));
    dq.push_back(mk(100000, 0, -100000, 46341, 0, 46341, 1647100));
    dq.push_back(mk(100000, 0, -100000, 46341, 0, 46341, 4941298));
    foreach (dq[i]) send_word(dq[i], 1'b1);

    // sender pauses until all results are back
    drain();
    for (int i = 0; i < N_RAND; i++) begin
      if (i == 400) begin
        hold_long = 1'b1;
      end
      if (i == 900) drain();
      send_word(rand_word(), !(i >= 400 && i < 700) && !(i >= 1200 && i < 1350));
    end

    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== axis_angle_vector_rotate_top.f =====
+incdir+sv
sv/aavr_pkg.sv
sv/aavr_if.sv
sv/aavr_reduce.sv
sv/aavr_cordic_cell.sv
sv/aavr_rodrigues.sv
sv/axis_angle_vector_rotate_top.sv
sv/aavr_checker.sv
verif/aavr_tb_if.sv
verif/axis_angle_vector_rotate_top_tb.sv
